[hw/rtl/spline_kernel_accumulator_unit_macros.svh]
// Assertion macros shared by the spline kernel accumulator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SPLINE_KERNEL_ACCUMULATOR_UNIT_MACROS_SVH
`define SPLINE_KERNEL_ACCUMULATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define SKA_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

`define SKA_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SKA_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg)

`define SKA_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg)

`endif

`endif

[hw/rtl/ska_pkg.sv]
// Package for the spline kernel accumulator: sizes, types and state codes.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ska_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS    = 12;
    localparam int ACC_WIDTH    = 48;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam int SUM_W       = SAMPLE_WIDTH + 1;
    localparam int PROD_W      = 2 * SAMPLE_WIDTH;
    localparam int K3_W        = SAMPLE_WIDTH + 2;
    localparam int T1_W        = 3 * SAMPLE_WIDTH;
    localparam int T2_W        = SUM_W + PROD_W;
    localparam int Q_W         = K3_W + PROD_W;
    localparam int RECIP_SHIFT = SAMPLE_WIDTH + 1;

    localparam int S_BASE = (3 * SAMPLE_WIDTH > 2 * SAMPLE_WIDTH + FRAC_BITS + 1) ?
                            3 * SAMPLE_WIDTH : 2 * SAMPLE_WIDTH + FRAC_BITS + 1;
    localparam int S_W    = ((S_BASE > 3 * FRAC_BITS + 2) ? S_BASE : 3 * FRAC_BITS + 2) + 3;
    localparam int TERM_SHIFT = 2 * FRAC_BITS + 1;
    localparam int TERM_W     = S_W - TERM_SHIFT;
    localparam int ACCX_W     = ((ACC_WIDTH > TERM_W) ? ACC_WIDTH : TERM_W) + 1;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic        [SAMPLE_WIDTH-1:0] sample_u_t;
    typedef logic signed [SUM_W-1:0]        sum_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic        [PROD_W-1:0]       prod_u_t;
    typedef logic signed [K3_W-1:0]         k3_t;
    typedef logic signed [2:0]              r_t;
    typedef logic signed [T1_W-1:0]         t1_t;
    typedef logic signed [T2_W-1:0]         t2_t;
    typedef logic signed [Q_W-1:0]          q_t;
    typedef logic signed [S_W-1:0]          wide_t;
    typedef logic signed [TERM_W-1:0]       term_t;
    typedef logic signed [ACCX_W-1:0]       accx_t;
    typedef logic signed [ACC_WIDTH-1:0]    acc_t;

    // Reciprocal of three, rounded up, scaled by 2^RECIP_SHIFT.
    localparam sample_u_t RECIP3 =
        SAMPLE_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);

    localparam r_t    R_TWO    = r_t'(2);
    localparam wide_t ONE_BIAS = wide_t'(1) <<< (3 * FRAC_BITS + 1);
    localparam accx_t ACC_MAX  = accx_t'({1'b0, {(ACC_WIDTH-1){1'b1}}});
    localparam accx_t ACC_MIN  = -ACC_MAX - accx_t'(1);

    typedef struct packed {
        sample_t x;
        sample_t y;
        sample_t m;
        sum_t    sum;
        logic    last;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_CROSS,
        ST_CUBE,
        ST_SCALE,
        ST_TERM,
        ST_ACC
    } back_state_t;

endpackage

`default_nettype wire

[hw/rtl/spline_kernel_accumulator_unit.sv]
// Top level of the spline kernel accumulator.
// Depends on ska_pkg, ska_front and ska_back.
`timescale 1ns / 1ps
`default_nettype none

// Accumulates the spline kernel term of each element pair and returns the saturated sum
// when the pair marked last has been added. Items enter a four-entry queue and are then
// worked off one at a time by a sequenced datapath: in the back part each item passes
// through its chain of dependent multiplies (products, cross terms, cube over three,
// scaling) followed by the accumulate step. The queue takes up to four
// items while the datapath is busy, and a finished result waits in its own output slot,
// so new items keep flowing until a second result is ready while the first is not taken.
module spline_kernel_accumulator_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  ska_pkg::sample_t  x_elem,
    input  ska_pkg::sample_t  y_elem,
    input  logic              last_elem,
    output logic              empty,
    input  logic              pop,
    output ska_pkg::acc_t     kernel_value,
    output logic              saturated
);

    logic            head_valid;
    logic            head_pop;
    ska_pkg::entry_t head;

    ska_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .x_elem     (x_elem),
        .y_elem     (y_elem),
        .last_elem  (last_elem),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    ska_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .head_pop     (head_pop),
        .empty        (empty),
        .pop          (pop),
        .kernel_value (kernel_value),
        .saturated    (saturated)
    );

endmodule

`default_nettype wire

[hw/rtl/ska_front.sv]
// Front part of the spline kernel accumulator: takes items, forms min and sum, queues them.
// Depends on ska_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "spline_kernel_accumulator_unit_macros.svh"

module ska_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  ska_pkg::sample_t  x_elem,
    input  ska_pkg::sample_t  y_elem,
    input  logic              last_elem,
    output logic              head_valid,
    output ska_pkg::entry_t   head,
    input  logic              head_pop
);

    ska_pkg::entry_t                   q_mem_reg [ska_pkg::QUEUE_DEPTH];
    logic [ska_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [ska_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [ska_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [ska_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [ska_pkg::QCNT_W-1:0]        count_reg;
    logic [ska_pkg::QCNT_W-1:0]        count_next;
    logic                              take;
    ska_pkg::entry_t                   entry_next;

    assign full       = (count_reg == ska_pkg::QCNT_W'(ska_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = q_mem_reg[rd_ptr_reg];
    assign take       = push && !full;

    always_comb
    begin
        entry_next.x    = x_elem;
        entry_next.y    = y_elem;
        entry_next.m    = (x_elem < y_elem) ? x_elem : y_elem;
        entry_next.sum  = ska_pkg::sum_t'(x_elem) + ska_pkg::sum_t'(y_elem);
        entry_next.last = last_elem;
    end

    always_comb
    begin
        wr_ptr_next = take ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = head_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + ska_pkg::QCNT_W'(take) - ska_pkg::QCNT_W'(head_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            q_mem_reg[wr_ptr_reg] <= entry_next;
        end
    end

    `SKA_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= ska_pkg::QCNT_W'(ska_pkg::QUEUE_DEPTH), "queue count above depth")
    `SKA_ASSERT_NOW(a_pop_valid, clk, rst_n, head_pop, head_valid, "pop from empty queue")

endmodule

`default_nettype wire

[hw/rtl/ska_back.sv]
// Back part of the spline kernel accumulator: sequenced term datapath, saturating sum, result slot.
// Depends on ska_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "spline_kernel_accumulator_unit_macros.svh"

module ska_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  ska_pkg::entry_t   head,
    output logic              head_pop,
    output logic              empty,
    input  logic              pop,
    output ska_pkg::acc_t     kernel_value,
    output logic              saturated
);

    ska_pkg::back_state_t state_reg;
    ska_pkg::back_state_t state_next;

    ska_pkg::sample_t x_reg;
    ska_pkg::sample_t y_reg;
    ska_pkg::sample_t m_reg;
    ska_pkg::sum_t    sum_in_reg;
    logic             last_reg;

    ska_pkg::prod_t   xy_reg;
    ska_pkg::prod_t   xy_next;
    ska_pkg::prod_t   mm_reg;
    ska_pkg::prod_t   mm_next;
    ska_pkg::sample_t k_reg;
    ska_pkg::sample_t k_next;
    ska_pkg::r_t      r_reg;
    ska_pkg::r_t      r_next;
    ska_pkg::t1_t     t1_reg;
    ska_pkg::t1_t     t1_next;
    ska_pkg::t2_t     t2_reg;
    ska_pkg::t2_t     t2_next;
    ska_pkg::prod_t   kk_reg;
    ska_pkg::prod_t   kk_next;
    ska_pkg::prod_t   c_reg;
    ska_pkg::prod_t   c_next;
    ska_pkg::r_t      e_reg;
    ska_pkg::r_t      e_next;
    ska_pkg::k3_t     k3_reg;
    ska_pkg::k3_t     k3_next;
    ska_pkg::q_t      q_reg;
    ska_pkg::q_t      q_next;
    ska_pkg::wide_t   base_reg;
    ska_pkg::wide_t   base_next;
    ska_pkg::term_t   term_reg;
    ska_pkg::term_t   term_next;

    ska_pkg::acc_t    sum_reg;
    ska_pkg::acc_t    sum_next;
    logic             clip_reg;
    logic             clip_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    ska_pkg::acc_t    out_value_reg;
    logic             out_sat_reg;

    logic                  advance;
    logic                  emit;
    ska_pkg::sample_u_t    mag;
    ska_pkg::prod_u_t      kprod;
    ska_pkg::k3_t          k3_w;
    ska_pkg::wide_t        s_full;
    ska_pkg::accx_t        acc_sum;
    ska_pkg::accx_t        acc_sat;
    logic                  clip_now;

    always_comb
    begin
        unique case (state_reg)
            ska_pkg::ST_IDLE:  state_next = head_valid ? ska_pkg::ST_PROD : ska_pkg::ST_IDLE;
            ska_pkg::ST_PROD:  state_next = ska_pkg::ST_CROSS;
            ska_pkg::ST_CROSS: state_next = ska_pkg::ST_CUBE;
            ska_pkg::ST_CUBE:  state_next = ska_pkg::ST_SCALE;
            ska_pkg::ST_SCALE: state_next = ska_pkg::ST_TERM;
            ska_pkg::ST_TERM:  state_next = ska_pkg::ST_ACC;
            ska_pkg::ST_ACC:   state_next = advance ? ska_pkg::ST_IDLE : ska_pkg::ST_ACC;
            default:           state_next = ska_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        head_pop = (state_reg == ska_pkg::ST_IDLE) && head_valid;
        advance  = (state_reg == ska_pkg::ST_ACC) && (!last_reg || !out_valid_reg || pop);
        emit     = advance && last_reg;
    end

    // The cube over three is split as m = 3k + r with k and r of the same sign.
    always_comb
    begin
        xy_next = ska_pkg::prod_t'(x_reg) * ska_pkg::prod_t'(y_reg);
        mm_next = ska_pkg::prod_t'(m_reg) * ska_pkg::prod_t'(m_reg);
        mag     = m_reg[ska_pkg::SAMPLE_WIDTH-1] ? ska_pkg::sample_u_t'(-m_reg)
                                                 : ska_pkg::sample_u_t'(m_reg);
        kprod   = ska_pkg::prod_u_t'(mag) * ska_pkg::prod_u_t'(ska_pkg::RECIP3);
        k_next  = ska_pkg::sample_t'(kprod[ska_pkg::PROD_W-1:ska_pkg::RECIP_SHIFT]);
        if (m_reg[ska_pkg::SAMPLE_WIDTH-1])
        begin
            k_next = -k_next;
        end

        k3_w    = ska_pkg::k3_t'(k_reg) + (ska_pkg::k3_t'(k_reg) <<< 1);
        r_next  = ska_pkg::r_t'(ska_pkg::k3_t'(m_reg) - k3_w);
        t1_next = ska_pkg::t1_t'(xy_reg) * ska_pkg::t1_t'(m_reg);
        t2_next = ska_pkg::t2_t'(sum_in_reg) * ska_pkg::t2_t'(mm_reg);
        kk_next = ska_pkg::prod_t'(k_reg) * ska_pkg::prod_t'(k_reg);

        c_next  = kk_reg + (kk_reg <<< 1)
                + ska_pkg::prod_t'(r_reg) * ska_pkg::prod_t'(k3_w)
                + ska_pkg::prod_t'(r_reg) * ska_pkg::prod_t'(r_reg);
        k3_next = k3_w;
        if (r_reg == ska_pkg::R_TWO)
        begin
            e_next = ska_pkg::R_TWO;
        end
        else if (r_reg == -ska_pkg::R_TWO)
        begin
            e_next = -ska_pkg::R_TWO;
        end
        else
        begin
            e_next = '0;
        end

        q_next    = ska_pkg::q_t'(k3_reg) * ska_pkg::q_t'(c_reg);
        base_next = ska_pkg::ONE_BIAS
                  + (ska_pkg::wide_t'(xy_reg) <<< (ska_pkg::FRAC_BITS + 1))
                  + (ska_pkg::wide_t'(t1_reg) <<< 1)
                  - ska_pkg::wide_t'(t2_reg);

        s_full    = base_reg + ((ska_pkg::wide_t'(q_reg) + ska_pkg::wide_t'(e_reg)) <<< 1);
        term_next = ska_pkg::term_t'(s_full >>> ska_pkg::TERM_SHIFT);
    end

    always_comb
    begin
        acc_sum  = ska_pkg::accx_t'(sum_reg) + ska_pkg::accx_t'(term_reg);
        clip_now = (acc_sum > ska_pkg::ACC_MAX) || (acc_sum < ska_pkg::ACC_MIN);
        if (acc_sum > ska_pkg::ACC_MAX)
        begin
            acc_sat = ska_pkg::ACC_MAX;
        end
        else if (acc_sum < ska_pkg::ACC_MIN)
        begin
            acc_sat = ska_pkg::ACC_MIN;
        end
        else
        begin
            acc_sat = acc_sum;
        end

        sum_next  = sum_reg;
        clip_next = clip_reg;
        if (advance)
        begin
            if (last_reg)
            begin
                sum_next  = '0;
                clip_next = 1'b0;
            end
            else
            begin
                sum_next  = ska_pkg::acc_t'(acc_sat);
                clip_next = clip_reg || clip_now;
            end
        end
        out_valid_next = (out_valid_reg && !pop) || emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ska_pkg::ST_IDLE;
            sum_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop)
        begin
            x_reg      <= head.x;
            y_reg      <= head.y;
            m_reg      <= head.m;
            sum_in_reg <= head.sum;
            last_reg   <= head.last;
        end
        if (state_reg == ska_pkg::ST_PROD)
        begin
            xy_reg <= xy_next;
            mm_reg <= mm_next;
            k_reg  <= k_next;
        end
        if (state_reg == ska_pkg::ST_CROSS)
        begin
            r_reg  <= r_next;
            t1_reg <= t1_next;
            t2_reg <= t2_next;
            kk_reg <= kk_next;
        end
        if (state_reg == ska_pkg::ST_CUBE)
        begin
            c_reg  <= c_next;
            e_reg  <= e_next;
            k3_reg <= k3_next;
        end
        if (state_reg == ska_pkg::ST_SCALE)
        begin
            q_reg    <= q_next;
            base_reg <= base_next;
        end
        if (state_reg == ska_pkg::ST_TERM)
        begin
            term_reg <= term_next;
        end
        if (emit)
        begin
            out_value_reg <= ska_pkg::acc_t'(acc_sat);
            out_sat_reg   <= clip_reg || clip_now;
        end
    end

    assign empty        = !out_valid_reg;
    assign kernel_value = out_value_reg;
    assign saturated    = out_sat_reg;

    `SKA_ASSERT_NEXT(a_idle_hold, clk, rst_n,
        (state_reg == ska_pkg::ST_IDLE) && !head_valid,
        state_reg == ska_pkg::ST_IDLE, "sequencer left idle without an item")
    `SKA_ASSERT_NEXT(a_clear_after_last, clk, rst_n, emit,
        (sum_reg == '0) && !clip_reg && out_valid_reg, "sum not cleared after result")

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the spline kernel accumulator unit.
// Depends on ska_pkg and spline_kernel_accumulator_unit; predicts each kernel sum itself.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        ska_pkg::acc_t kernel;
        logic          sat;
    } kernel_result_t;

    localparam ska_pkg::sample_t SMAX = ska_pkg::sample_t'(16'h7FFF);
    localparam ska_pkg::sample_t SMIN = ska_pkg::sample_t'(16'h8000);

    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    ska_pkg::sample_t x_elem;
    ska_pkg::sample_t y_elem;
    logic             last_elem;
    logic             empty;
    logic             pop;
    ska_pkg::acc_t    kernel_value;
    logic             saturated;

    ska_pkg::acc_t    kernel_sum;
    logic             clip_flag;
    kernel_result_t   kernel_expect_q[$];

    bit send_idle_en;
    bit recv_idle_en;
    int recv_hold;
    int recv_stall;
    int item_count;
    int vector_count;
    int result_count;
    int fail_count;

    spline_kernel_accumulator_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .x_elem       (x_elem),
        .y_elem       (y_elem),
        .last_elem    (last_elem),
        .empty        (empty),
        .pop          (pop),
        .kernel_value (kernel_value),
        .saturated    (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[spline_kernel_accumulator_unit] ERROR");
        $finish;
    end

    function automatic logic signed [63:0] spline_term(input ska_pkg::sample_t x,
                                                       input ska_pkg::sample_t y);
        logic signed [127:0] xw;
        logic signed [127:0] yw;
        logic signed [127:0] mw;
        logic signed [127:0] xy;
        logic signed [127:0] cube;
        logic signed [127:0] s;
        xw   = x;
        yw   = y;
        mw   = (x < y) ? xw : yw;
        xy   = xw * yw;
        cube = mw * mw * mw;
        s    = (128'sd1 <<< (3 * ska_pkg::FRAC_BITS + 1))
             + (xy <<< (ska_pkg::FRAC_BITS + 1))
             + 128'sd2 * xy * mw
             - (xw + yw) * mw * mw
             + 128'sd2 * (cube / 128'sd3);
        return 64'(s >>> (2 * ska_pkg::FRAC_BITS + 1));
    endfunction

    task automatic accumulate_pair(input ska_pkg::sample_t x, input ska_pkg::sample_t y,
                                   input logic last);
        logic signed [127:0] total;
        logic signed [127:0] lim_hi;
        logic signed [127:0] lim_lo;
        kernel_result_t      r;
        lim_hi = (128'sd1 <<< (ska_pkg::ACC_WIDTH - 1)) - 128'sd1;
        lim_lo = -(128'sd1 <<< (ska_pkg::ACC_WIDTH - 1));
        total  = kernel_sum;
        total  = total + spline_term(x, y);
        if (total > lim_hi)
        begin
            total     = lim_hi;
            clip_flag = 1'b1;
        end
        else if (total < lim_lo)
        begin
            total     = lim_lo;
            clip_flag = 1'b1;
        end
        kernel_sum = ska_pkg::acc_t'(total);
        if (last)
        begin
            r.kernel = kernel_sum;
            r.sat    = clip_flag;
            kernel_expect_q.push_back(r);
            kernel_sum = '0;
            clip_flag  = 1'b0;
            vector_count++;
        end
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic check_result();
        kernel_result_t e;
        if (kernel_expect_q.size() == 0)
            note_failure($sformatf("result with no item pending: kernel_value=%0d saturated=%0b",
                                   kernel_value, saturated));
        else
        begin
            e = kernel_expect_q.pop_front();
            result_count++;
            if (kernel_value !== e.kernel || saturated !== e.sat)
                note_failure($sformatf("mismatch: kernel_value exp %0d got %0d, saturated exp %0b got %0b",
                                       e.kernel, kernel_value, e.sat, saturated));
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                check_result();
            if (recv_hold > 0)
            begin
                recv_hold--;
                pop <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                pop <= 1'b0;
            end
            else if (recv_idle_en && $urandom_range(0, 7) == 0)
            begin
                recv_stall = $urandom_range(1, 19) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic send_pair(input ska_pkg::sample_t x, input ska_pkg::sample_t y,
                             input logic last);
        int gap;
        gap = 0;
        if (send_idle_en && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        x_elem    <= x;
        y_elem    <= y;
        last_elem <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        accumulate_pair(x, y, last);
        item_count++;
    endtask

    task automatic sender_rest();
        push <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drain();
        while (kernel_expect_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic ska_pkg::sample_t rand_sample();
        int sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0:       return $urandom_range(0, 1) ? SMAX : SMIN;
            1:       return ska_pkg::sample_t'(int'($urandom_range(0, 8192)) - 4096);
            2:       return ska_pkg::sample_t'(int'($urandom_range(0, 15)) - 32768);
            3:       return ska_pkg::sample_t'(32767 - int'($urandom_range(0, 15)));
            default: return ska_pkg::sample_t'($urandom);
        endcase
    endfunction

    task automatic send_vector(input int len);
        ska_pkg::sample_t x;
        ska_pkg::sample_t y;
        for (int i = 0; i < len; i++)
        begin
            x = rand_sample();
            y = ($urandom_range(0, 7) == 0) ? x : rand_sample();
            send_pair(x, y, i == len - 1);
        end
    endtask

    function automatic int rand_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    endfunction

    task automatic test_directed();
        send_pair('0, '0, 1'b1);
        send_pair(SMAX, SMAX, 1'b1);
        send_pair(SMIN, SMIN, 1'b1);
        send_pair(SMIN, SMAX, 1'b1);
        send_pair(SMAX, SMIN, 1'b1);
        send_pair(-16'sd1, 16'sd1, 1'b1);
        send_pair(16'sd4096, 16'sd4096, 1'b1);
        send_pair(-16'sd4096, 16'sd2048, 1'b1);
        send_pair(16'sd3, -16'sd3, 1'b1);
        send_pair(16'sd100, -16'sd200, 1'b0);
        send_pair(SMAX, SMIN, 1'b0);
        send_pair(SMIN, SMIN, 1'b0);
        send_pair(SMAX, SMAX, 1'b0);
        send_pair(SMIN, SMAX, 1'b1);
        for (int i = 0; i < 8; i++)
            send_pair(SMIN, SMAX, i == 7);
        send_pair(16'sh5555, -16'sh2AAB, 1'b1);
        sender_rest();
    endtask

    task automatic test_random_vectors(input int n_items);
        int target;
        target = item_count + n_items;
        while (item_count < target)
            send_vector(rand_length());
        sender_rest();
    endtask

    task automatic test_receiver_hold();
        send_idle_en = 1'b0;
        recv_hold    = 400;
        for (int i = 0; i < 12; i++)
            send_vector($urandom_range(1, 6));
        sender_rest();
        send_idle_en = 1'b1;
    endtask

    task automatic test_drain_pause();
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 6; i++)
                send_vector(rand_length());
            sender_rest();
            wait_drain();
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        push         <= 1'b0;
        pop          <= 1'b0;
        x_elem       <= '0;
        y_elem       <= '0;
        last_elem    <= 1'b0;
        kernel_sum   = '0;
        clip_flag    = 1'b0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        recv_hold    = 0;
        recv_stall   = 0;
        item_count   = 0;
        vector_count = 0;
        result_count = 0;
        fail_count   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_vectors(500);
        test_receiver_hold();
        test_random_vectors(400);
        test_drain_pause();
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        test_random_vectors(200);

        wait_drain();
        repeat (100) @(posedge clk);
        $display("Sent %0d element pairs in %0d vectors and checked %0d kernel sums,",
                 item_count, vector_count, result_count);
        $display("with extreme inputs, random idling, a long receiver hold-off and drain pauses.");
        if (fail_count == 0 && kernel_expect_q.size() == 0)
            $display("[spline_kernel_accumulator_unit] OK");
        else
            $display("[spline_kernel_accumulator_unit] ERROR");
        $finish;
    end

endmodule
